[hdl/rat_pkg.sv]
// Shared types and constants for the range address translation table.
// Used by rat_cell, rat_probe, range_address_translation_table_top and the testbench.
// Depends on nothing else.
package rat_pkg;

   localparam int TableEntries = 16;
   localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
   localparam int AddrW = 64;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_H2G    = 2'd2,
      OP_G2H    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_COMPACT = 4'b0010,
      ST_SCAN    = 4'b0100,
      ST_FINISH  = 4'b1000
   } state_type;

   // One stored range as it travels along the chain.
   typedef struct packed {
      logic             valid;
      logic [AddrW-1:0] host_base;
      logic [AddrW-1:0] length;
      logic [AddrW-1:0] guest_base;
   } entry_type;

   // Broadcast command to every cell.
   typedef struct packed {
      logic             rotate;
      logic             compact;
      logic             append;
      logic [AddrW-1:0] host_addr;
      logic [AddrW-1:0] length;
      logic [AddrW-1:0] guest_addr;
   } cell_cmd_type;

   // Control of the lookup unit at the head of the chain.
   typedef struct packed {
      logic clear;
      logic enable;
      logic h2g;
   } probe_cmd_type;

endpackage

[hdl/rat_cell.sv]
// One storage cell of the translation table chain.
// Holds a single range and takes its neighbour's range on a shift.
// Depends on rat_pkg.
module rat_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rat_pkg::cell_cmd_type cmd,
   input  logic                  prev_valid,
   input  logic                  shift_in,
   input  rat_pkg::entry_type    next_entry,
   output logic                  shift_out,
   output rat_pkg::entry_type    entry
);
   import rat_pkg::*;

   logic             valid_ff, valid_in;
   logic [AddrW-1:0] host_ff, host_in;
   logic [AddrW-1:0] length_ff, length_in;
   logic [AddrW-1:0] guest_ff, guest_in;
   logic             kill;

   // A cell matching the remove key starts the left shift from here upwards.
   assign kill      = valid_ff && (guest_ff == cmd.guest_addr) && (length_ff == cmd.length);
   assign shift_out = shift_in | kill;

   always_comb begin
      valid_in  = valid_ff;
      host_in   = host_ff;
      length_in = length_ff;
      guest_in  = guest_ff;
      priority if (cmd.rotate || (cmd.compact && shift_out)) begin
         valid_in  = next_entry.valid;
         host_in   = next_entry.host_base;
         length_in = next_entry.length;
         guest_in  = next_entry.guest_base;
      end else if (cmd.append && !valid_ff && prev_valid) begin
         valid_in  = 1'b1;
         host_in   = cmd.host_addr;
         length_in = cmd.length;
         guest_in  = cmd.guest_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      host_ff   <= host_in;
      length_ff <= length_in;
      guest_ff  <= guest_in;
   end

   assign entry = '{valid: valid_ff, host_base: host_ff, length: length_ff,
                    guest_base: guest_ff};

endmodule

[hdl/rat_probe.sv]
// Lookup unit at the head of the translation table chain.
// Tests the range passing the head each cycle and keeps the first hit.
// Depends on rat_pkg.
module rat_probe (
   input  logic                   clock,
   input  logic                   reset,
   input  rat_pkg::probe_cmd_type ctrl,
   input  logic [63:0]            addr,
   input  rat_pkg::entry_type     head,
   output logic                   found,
   output logic [63:0]            result_addr
);
   import rat_pkg::*;

   logic             hit_ff, hit_in;
   logic [AddrW-1:0] other_ff, other_in;
   logic [AddrW-1:0] diff_ff, diff_in;
   logic [AddrW-1:0] base;
   logic [AddrW-1:0] other;
   logic [AddrW-1:0] diff;
   logic             in_range;

   assign base  = ctrl.h2g ? head.host_base : head.guest_base;
   assign other = ctrl.h2g ? head.guest_base : head.host_base;
   assign diff  = addr - base;

   // The range end must not wrap past the top of the address space, which is
   // the same as the length not exceeding the complement of the base.
   assign in_range = head.valid && (addr >= base) && (diff < head.length)
                     && (head.length <= ~base);

   always_comb begin
      hit_in   = hit_ff;
      other_in = other_ff;
      diff_in  = diff_ff;
      priority if (ctrl.clear) begin
         hit_in = 1'b0;
      end else if (ctrl.enable && in_range && !hit_ff) begin
         hit_in   = 1'b1;
         other_in = other;
         diff_in  = diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      other_ff <= other_in;
      diff_ff  <= diff_in;
   end

   assign found       = hit_ff;
   assign result_addr = hit_ff ? (other_ff + diff_ff) : '0;

endmodule

[hdl/range_address_translation_table_top.sv]
// Top level of the range address translation table.
// Builds the chain of rat_cell instances, the rat_probe lookup unit and
// the command sequencer. Depends on rat_pkg, rat_cell and rat_probe.
//
// The table holds up to TableEntries ranges (host base, length, guest base)
// in insertion order, one range per cell of a chain. A request beat is taken
// when start is high and busy is low; exactly one response beat follows, on
// rsp_valid for a single cycle, and the receiver cannot stall it. An add is
// written into the first free cell in the cycle it is taken and answers in the
// next cycle. A remove compacts the chain one matching range per cycle until
// no matching range is left, and then answers. A lookup rotates the whole
// chain once past the lookup unit at its head, one cell per cycle, and then
// forms the translated address. A new request may be started in the cycle
// its predecessor's response is shown. After reset the table is empty.
module range_address_translation_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_host_addr,
   input  logic [63:0] req_length,
   input  logic [63:0] req_guest_addr,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_addr,
   output logic        rsp_found,
   output logic        rsp_status
);
   import rat_pkg::*;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

   // Sequencer state and the latched request.
   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic [AddrW-1:0] len_ff, len_in;
   logic [AddrW-1:0] guest_ff, guest_in;
   logic [IdxW-1:0]  count_ff, count_in;

   // Response register, held apart from the sequencer so that a new beat can
   // be taken while the last response is on the ports.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [AddrW-1:0] rsp_addr_ff, rsp_addr_in;
   logic             rsp_found_ff, rsp_found_in;
   logic             rsp_status_ff, rsp_status_in;

   op_type           req_op_t;
   cell_cmd_type     cmd;
   probe_cmd_type    probe_cmd;
   entry_type        cell_entry [TableEntries];
   entry_type        chain_next [TableEntries];
   entry_type        tail_entry;
   logic [TableEntries-1:0] prev_valid;
   logic [TableEntries-1:0] shift_in;
   logic [TableEntries-1:0] shift_chain;
   logic [TableEntries-1:0] valid_vec;
   logic                    probe_found;
   logic [AddrW-1:0]        probe_result;

   assign req_op_t = op_type'(req_op);
   assign busy     = (state_ff != ST_IDLE);

   // During a rotation the head range wraps round to the tail; during a
   // compaction an empty range enters at the tail instead.
   always_comb begin
      tail_entry       = cell_entry[0];
      tail_entry.valid = cell_entry[0].valid & cmd.rotate;
   end

   genvar i;
   generate
      for (i = 0; i < TableEntries; i++) begin : g_cell
         if (i == TableEntries - 1) begin : g_tail
            assign chain_next[i] = tail_entry;
         end else begin : g_mid
            assign chain_next[i] = cell_entry[i+1];
         end
         if (i == 0) begin : g_head
            assign prev_valid[i] = 1'b1;
            assign shift_in[i]   = 1'b0;
         end else begin : g_rest
            assign prev_valid[i] = cell_entry[i-1].valid;
            assign shift_in[i]   = shift_chain[i-1];
         end
         assign valid_vec[i] = cell_entry[i].valid;

         rat_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .prev_valid (prev_valid[i]),
            .shift_in   (shift_in[i]),
            .next_entry (chain_next[i]),
            .shift_out  (shift_chain[i]),
            .entry      (cell_entry[i])
         );
      end
   endgenerate

   rat_probe u_probe (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (probe_cmd),
      .addr        (addr_ff),
      .head        (cell_entry[0]),
      .found       (probe_found),
      .result_addr (probe_result)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      guest_in      = guest_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;

      // An add uses the request ports directly; a remove uses the latched key.
      cmd.rotate     = 1'b0;
      cmd.compact    = 1'b0;
      cmd.append     = 1'b0;
      cmd.host_addr  = req_host_addr;
      cmd.length     = busy ? len_ff : req_length;
      cmd.guest_addr = busy ? guest_ff : req_guest_addr;

      probe_cmd.clear  = 1'b0;
      probe_cmd.enable = 1'b0;
      probe_cmd.h2g    = (op_ff == OP_H2G);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in           = req_op_t;
               len_in          = req_length;
               guest_in        = req_guest_addr;
               addr_in         = (req_op_t == OP_H2G) ? req_host_addr : req_guest_addr;
               count_in        = '0;
               probe_cmd.clear = 1'b1;
               unique case (req_op_t)
                  OP_ADD: begin
                     // A full table has no free cell, so nothing is written.
                     cmd.append    = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_addr_in   = '0;
                     rsp_found_in  = 1'b0;
                     rsp_status_in = cell_entry[TableEntries-1].valid;
                  end
                  OP_REMOVE: begin
                     state_in = ST_COMPACT;
                  end
                  OP_H2G, OP_G2H: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_COMPACT: begin
            // Each cycle drops the first matching range; done when none is left.
            cmd.compact = 1'b1;
            if (!shift_chain[TableEntries-1]) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_found_in  = 1'b0;
               rsp_status_in = 1'b0;
            end
         end
         ST_SCAN: begin
            cmd.rotate       = 1'b1;
            probe_cmd.enable = 1'b1;
            count_in         = count_ff + 1'b1;
            if (count_ff == LastIdx) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = probe_result;
            rsp_found_in  = probe_found;
            rsp_status_in = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      guest_ff      <= guest_in;
      count_ff      <= count_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;

   // Used ranges always sit at the front of the chain, except mid-rotation.
   logic [TableEntries-1:0] valid_inc;
   assign valid_inc = valid_vec + 1'b1;

   a_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> ((valid_vec & valid_inc) == '0))
      else $error("used ranges do not form a prefix of the chain");

   a_add_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op_t == OP_ADD)) |=> rsp_valid)
      else $error("add beat not answered in the next cycle");

   a_quiet_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("response shown while a request is still in progress");

   a_scan_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> ($countones(valid_vec) == $past($countones(valid_vec))))
      else $error("rotation changed the number of stored ranges");

   a_compact_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPACT) |=> ($countones(valid_vec) <= $past($countones(valid_vec))))
      else $error("compaction grew the table");

endmodule

[verif/tb_range_address_translation_table_top.sv]
// Self-checking testbench for range_address_translation_table_top: directed beats, then
// random add, remove and lookup traffic, checked against a behavioural table model kept
// here or against typed rows of the directed table. Depends on rat_pkg and the RTL.
module tb_range_address_translation_table_top;
   import rat_pkg::*;

   // Generous ceiling on the run, in cycles.
   localparam int CycleLimit = 400000;
   // Random beats per idling phase; the three phases give 1425 in total.
   localparam int BeatsPerPhase = 475;
   localparam logic [AddrW-1:0] AllOnes = '1;

   // One expected response beat.
   typedef struct packed {
      logic [AddrW-1:0] addr;
      logic             found;
      logic             status;
   } xlate_rsp_type;

   // One row of the directed table. Where typed is set, the response is the one
   // written in the row; otherwise the table model works it out.
   typedef struct packed {
      op_type           op;
      logic [AddrW-1:0] host;
      logic [AddrW-1:0] len;
      logic [AddrW-1:0] guest;
      logic             typed;
      xlate_rsp_type    rsp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = OP_ADD;
   logic [63:0] req_host_addr = '0;
   logic [63:0] req_length = '0;
   logic [63:0] req_guest_addr = '0;
   logic        rsp_valid;
   logic [63:0] rsp_result_addr;
   logic        rsp_found;
   logic        rsp_status;

   // The table model: the mapped ranges in insertion order, the first
   // map_count of them in use.
   logic [AddrW-1:0] map_host [TableEntries];
   logic [AddrW-1:0] map_len [TableEntries];
   logic [AddrW-1:0] map_guest [TableEntries];
   int               map_count = 0;

   xlate_rsp_type expected_rsps[$];
   int            error_count = 0;
   int            beats_sent = 0;
   int            rsps_checked = 0;
   int            lookup_hits = 0;
   int            adds_dropped = 0;
   int            cycle_count = 0;

   directed_row_type directed_rows [25];

   range_address_translation_table_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_host_addr   (req_host_addr),
      .req_length      (req_length),
      .req_guest_addr  (req_guest_addr),
      .rsp_valid       (rsp_valid),
      .rsp_result_addr (rsp_result_addr),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding", $time,
                  cycle_count, expected_rsps.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [AddrW-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Applies one request to the table model and returns the response it calls
   // for. The range end and the translated address both wrap modulo 2^64, so a
   // range whose end wraps never matches, and neither does one of zero length.
   function automatic xlate_rsp_type translate_model(input op_type op,
                                                     input logic [AddrW-1:0] host,
                                                     input logic [AddrW-1:0] len,
                                                     input logic [AddrW-1:0] guest);
      xlate_rsp_type    rsp;
      int               kept;
      logic [AddrW-1:0] addr;
      logic [AddrW-1:0] base;
      logic [AddrW-1:0] other;
      logic [AddrW-1:0] lim;
      rsp = '0;
      case (op)
         OP_ADD: begin
            if (map_count < TableEntries) begin
               map_host[map_count] = host;
               map_len[map_count] = len;
               map_guest[map_count] = guest;
               map_count++;
            end else begin
               rsp.status = 1'b1;
            end
         end
         OP_REMOVE: begin
            // Every range matching on guest base and length goes; the rest
            // close up in their original order.
            kept = 0;
            for (int i = 0; i < map_count; i++) begin
               if (!(map_guest[i] == guest && map_len[i] == len)) begin
                  map_host[kept] = map_host[i];
                  map_len[kept] = map_len[i];
                  map_guest[kept] = map_guest[i];
                  kept++;
               end
            end
            map_count = kept;
         end
         default: begin
            addr = (op == OP_H2G) ? host : guest;
            for (int i = 0; i < map_count; i++) begin
               base = (op == OP_H2G) ? map_host[i] : map_guest[i];
               other = (op == OP_H2G) ? map_guest[i] : map_host[i];
               lim = base + map_len[i];
               if (!rsp.found && addr >= base && addr < lim) begin
                  rsp.addr = other + (addr - base);
                  rsp.found = 1'b1;
               end
            end
         end
      endcase
      return rsp;
   endfunction

   // Presents one request beat and holds it until the block takes it, then
   // records the response that beat must produce. Start is left high, so that
   // back-to-back beats need no second assignment to it within a time step.
   task automatic issue(input op_type op, input logic [AddrW-1:0] host,
                        input logic [AddrW-1:0] len, input logic [AddrW-1:0] guest,
                        input logic typed, input xlate_rsp_type typed_rsp);
      xlate_rsp_type predicted;
      start <= 1'b1;
      req_op <= op;
      req_host_addr <= host;
      req_length <= len;
      req_guest_addr <= guest;
      do @(posedge clock); while (busy);
      predicted = translate_model(op, host, len, guest);
      expected_rsps.insert(expected_rsps.size(), typed ? typed_rsp : predicted);
      beats_sent++;
   endtask

   // Now and then the sender drops start for a while, so that gaps land at
   // every point of a lookup's rotation and of a remove's compaction.
   task automatic sender_gap(input int idle_pct);
      int gap;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 24);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One random beat. Most beats are built from the ranges the table holds at
   // the time: removes that hit stored guest bases and lengths, lookups that
   // fall inside stored ranges, and adds that repeat a stored guest base and
   // length so that a single remove takes several ranges out. The remainder is
   // fully random. When draining, removes outweigh adds; otherwise the table
   // fills up and adds start to be dropped.
   task automatic random_beat(input logic draining);
      op_type           op;
      logic [AddrW-1:0] host;
      logic [AddrW-1:0] len;
      logic [AddrW-1:0] guest;
      logic [AddrW-1:0] base;
      logic [AddrW-1:0] offset;
      int               pick;
      int               add_pct;
      int               remove_pct;
      int               idx;
      host = rand64();
      len = rand64();
      guest = rand64();
      add_pct = draining ? 10 : 40;
      remove_pct = draining ? 45 : 10;
      idx = (map_count > 0) ? $urandom_range(0, map_count - 1) : 0;
      pick = $urandom_range(0, 99);
      if (pick < add_pct) begin
         op = OP_ADD;
         case ($urandom_range(0, 9))
            0, 1: begin
               if (map_count > 0) begin
                  len = map_len[idx];
                  guest = map_guest[idx];
               end
            end
            2: len = '0;
            3: len = AllOnes;
            4: ; // Keep the fully random length; its end often wraps.
            default: len = AddrW'($urandom_range(1, 65536));
         endcase
      end else if (pick < add_pct + remove_pct) begin
         op = OP_REMOVE;
         if (map_count > 0 && $urandom_range(0, 3) != 0) begin
            len = map_len[idx];
            guest = map_guest[idx];
         end
      end else begin
         op = $urandom_range(0, 1) ? OP_H2G : OP_G2H;
         if (map_count > 0 && $urandom_range(0, 3) != 0) begin
            base = (op == OP_H2G) ? map_host[idx] : map_guest[idx];
            offset = (map_len[idx] == '0) ? '0 : rand64() % map_len[idx];
            if (op == OP_H2G) begin
               host = base + offset;
            end else begin
               guest = base + offset;
            end
         end
      end
      issue(op, host, len, guest, 1'b0, '0);
   endtask

   // Response checker. Sampling on the falling edge sees each response beat in
   // the middle of its single cycle, well clear of the rising edge at which the
   // driver records new expectations.
   always @(negedge clock) begin
      xlate_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: response beat with nothing outstanding: addr %h found %b status %b",
                     $time, rsp_result_addr, rsp_found, rsp_status);
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            rsps_checked++;
            if (rsp_found === 1'b1) lookup_hits++;
            if (rsp_status === 1'b1) adds_dropped++;
            if (rsp_result_addr !== exp_rsp.addr) begin
               $display("%0t: result_addr mismatch, expected %h, actual %h", $time,
                        exp_rsp.addr, rsp_result_addr);
               error_count++;
            end
            if (rsp_found !== exp_rsp.found) begin
               $display("%0t: found mismatch, expected %b, actual %b", $time,
                        exp_rsp.found, rsp_found);
               error_count++;
            end
            if (rsp_status !== exp_rsp.status) begin
               $display("%0t: status mismatch, expected %b, actual %b", $time,
                        exp_rsp.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      int phase_idle [3];

      // Directed part. The table is first probed while empty, then filled to
      // its last entry with special ranges: a plain one, one of zero length,
      // one whose end wraps past the top of the address space, one whose
      // translation wraps, one overlapping the first, and a run that repeats
      // the first range's guest base and length. One more add is dropped as
      // the table is full. Lookups then check first-match priority, the wrap
      // cases and the zero-length range; a remove takes the repeated ranges
      // out together and the overlapping range becomes the first match.
      directed_rows = '{
         '{OP_G2H,    '0, '0, AllOnes, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_REMOVE, '0, AllOnes, AllOnes, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_ADD, 64'h1000, 64'h100, 64'h8000, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_ADD, '0, '0, '0, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 64'h4000, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_ADD, 64'h2000, 64'h100, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_ADD, 64'h1000, 64'h1000, 64'h9000, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_ADD, 64'h0010_0000, 64'h100, 64'h8000, 1'b0, '0},
         '{OP_ADD, 64'h0020_0000, 64'h100, 64'h0040_0000, 1'b0, '0},
         '{OP_ADD, 64'h0030_0000, 64'h100, 64'h8000, 1'b0, '0},
         '{OP_ADD, 64'h0040_0000, 64'h100, 64'h0080_0000, 1'b0, '0},
         '{OP_ADD, 64'h0050_0000, 64'h100, 64'h8000, 1'b0, '0},
         '{OP_ADD, 64'h0060_0000, 64'h100, 64'h00C0_0000, 1'b0, '0},
         '{OP_ADD, 64'h0070_0000, 64'h100, 64'h8000, 1'b0, '0},
         '{OP_ADD, 64'h0080_0000, 64'h100, 64'h0100_0000, 1'b0, '0},
         '{OP_ADD, 64'h0090_0000, 64'h100, 64'h8000, 1'b0, '0},
         '{OP_ADD, 64'h00A0_0000, 64'h100, 64'h0140_0000, 1'b0, '0},
         '{OP_ADD, 64'h7FFF_FFFF_FFFF_FF00, 64'h100, 64'hFFFF_FFFF_FFFF_FF00, 1'b1,
           '{'0, 1'b0, 1'b0}},
         '{OP_ADD, AllOnes, AllOnes, AllOnes, 1'b1, '{'0, 1'b0, 1'b1}},
         '{OP_G2H, '0, '0, 64'h8050, 1'b1, '{64'h1050, 1'b1, 1'b0}},
         '{OP_H2G, 64'h2020, '0, '0, 1'b1, '{64'h10, 1'b1, 1'b0}},
         '{OP_H2G, 64'hFFFF_FFFF_FFFF_F800, '0, '0, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_H2G, '0, '0, '0, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_REMOVE, '0, 64'h100, 64'h8000, 1'b1, '{'0, 1'b0, 1'b0}},
         '{OP_H2G, 64'h1050, '0, '0, 1'b1, '{64'h9050, 1'b1, 1'b0}}
      };
      // Sender idling per random phase: light, heavy, then none at all.
      phase_idle = '{21, 68, 0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         issue(directed_rows[r].op, directed_rows[r].host, directed_rows[r].len,
               directed_rows[r].guest, directed_rows[r].typed, directed_rows[r].rsp);
      end

      // Random part. Fill and drain spells of 64 beats alternate, so the table
      // swings between empty and full many times within each phase.
      for (int phase = 0; phase < 3; phase++) begin
         for (int k = 0; k < BeatsPerPhase; k++) begin
            random_beat(((k / 64) % 2) == 1);
            sender_gap(phase_idle[phase]);
         end
      end
      start <= 1'b0;

      // Let the last responses arrive, then allow a full lookup's worth of
      // cycles for any stray beat to show itself.
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (TableEntries + 4) @(posedge clock);

      $display("Sent %0d request beats and checked %0d responses in %0d cycles.", beats_sent,
               rsps_checked, cycle_count);
      $display("Lookup hits: %0d; adds dropped on a full table: %0d; mismatches: %0d.",
               lookup_hits, adds_dropped, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/rat_pkg.sv
hdl/rat_cell.sv
hdl/rat_probe.sv
hdl/range_address_translation_table_top.sv
verif/tb_range_address_translation_table_top.sv
